// ===== rtl/v4n_pkg.sv =====
`default_nettype none
package v4n_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQ_STAGES     = 32;
  localparam int MIN_LEN_W     = 17;
  localparam int LEN_W         = 33;
  localparam int MAG_W         = 31;
  localparam logic [MIN_LEN_W-1:0] MIN_LEN_RST = 17'd7;
  localparam logic [MAG_W-1:0]     MAG_MAX     = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    ACT_ADD  = 3'd0,
    ACT_SUB  = 3'd1,
    ACT_MUL  = 3'd2,
    ACT_NEG  = 3'd3,
    ACT_NORM = 3'd4,
    ACT_LEN  = 3'd5
  } action_e;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } clip_t;

  typedef struct packed {
    logic [31:0] r;
    logic        sat;
    logic        neg;
    logic [31:0] abs;
    logic [63:0] sq;
  } lane_out_t;

  function automatic clip_t clip32(logic signed [63:0] v);
    clip_t c;
    if (v > 64'sd2147483647) begin
      c.sat = 1'b1;
      c.val = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      c.sat = 1'b1;
      c.val = 32'h8000_0000;
    end else begin
      c.sat = 1'b0;
      c.val = v[31:0];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/v4n_in_if.sv =====
`default_nettype none
interface v4n_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] a_w;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] b_w;

  modport source (output valid, action, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                  input ready);
  modport sink (input valid, action, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/v4n_out_if.sv =====
`default_nettype none
interface v4n_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] r_w;
  logic [30:0]        magnitude;
  logic               too_short;
  logic               saturated;

  modport source (output valid, r_x, r_y, r_z, r_w, magnitude, too_short, saturated,
                  input ready);
  modport sink (input valid, r_x, r_y, r_z, r_w, magnitude, too_short, saturated,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/v4n_lane.sv =====
`default_nettype none
module v4n_lane #(
  parameter int FRAC_BITS = v4n_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [2:0]         action_i,
  input  wire logic signed [31:0] a_i,
  input  wire logic signed [31:0] b_i,
  output v4n_pkg::lane_out_t      res_o
);
  import v4n_pkg::*;

  lane_out_t          res_d, res_q;
  logic signed [63:0] prod, prnd, psh;
  logic [31:0]        abs_a;
  clip_t              c;

  always_comb begin
    prod  = 64'(a_i) * 64'(b_i);
    prnd  = prod + (64'sd1 <<< (FRAC_BITS - 1));
    psh   = prnd >>> FRAC_BITS;
    abs_a = a_i[31] ? (~a_i + 32'd1) : a_i;
    c     = '0;
    case (action_i)
      ACT_ADD: c = clip32(64'(a_i) + 64'(b_i));
      ACT_SUB: c = clip32(64'(a_i) - 64'(b_i));
      ACT_MUL: c = clip32(psh);
      ACT_NEG: c = clip32(-64'(a_i));
      default: c = '0;
    endcase
    res_d.r   = c.val;
    res_d.sat = c.sat;
    res_d.neg = a_i[31];
    res_d.abs = abs_a;
    res_d.sq  = 64'(abs_a) * 64'(abs_a);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;
endmodule
`default_nettype wire

// ===== rtl/v4n_sqrt.sv =====
`default_nettype none
module v4n_sqrt (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [63:0] v_i,
  output logic      [31:0] root_o
);
  import v4n_pkg::*;

  logic [63:0] v_q   [SQ_STAGES];
  logic [63:0] res_q [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    localparam int SH = 2 * (SQ_STAGES - 1 - s);
    logic [63:0] v_p, res_p, trial, v_d, res_d;
    if (s == 0) begin : g_first
      assign v_p   = v_i;
      assign res_p = '0;
    end else begin : g_next
      assign v_p   = v_q[s-1];
      assign res_p = res_q[s-1];
    end
    always_comb begin
      trial = res_p + (64'd1 << SH);
      if (v_p >= trial) begin
        v_d   = v_p - trial;
        res_d = (res_p >> 1) + (64'd1 << SH);
      end else begin
        v_d   = v_p;
        res_d = res_p >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[s]   <= v_d;
        res_q[s] <= res_d;
      end
    end
  end

  assign root_o = res_q[SQ_STAGES-1][31:0];
endmodule
`default_nettype wire

// ===== rtl/v4n_div_lane.sv =====
`default_nettype none
module v4n_div_lane #(
  parameter int FRAC_BITS = v4n_pkg::FRAC_BITS_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [FRAC_BITS+33:0]     num_i,
  input  wire logic [v4n_pkg::LEN_W-1:0] den_i,
  output logic      [FRAC_BITS:0]        quo_o
);
  import v4n_pkg::*;

  localparam int NW = FRAC_BITS + 34;
  localparam int QW = FRAC_BITS + 1;

  logic [NW-1:0]    rem_q [QW];
  logic [LEN_W-1:0] den_q [QW];
  logic [QW-1:0]    quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = FRAC_BITS - j;
    logic [NW-1:0]    rem_p, sh, rem_d;
    logic [LEN_W-1:0] den_p;
    logic [QW-1:0]    quo_p, quo_d;
    if (j == 0) begin : g_first
      assign rem_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[j-1];
      assign den_p = den_q[j-1];
      assign quo_p = quo_q[j-1];
    end
    always_comb begin
      sh = NW'(den_p) << K;
      if (rem_p >= sh) begin
        rem_d = rem_p - sh;
        quo_d = quo_p | (QW'(1) << K);
      end else begin
        rem_d = rem_p;
        quo_d = quo_p;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_p;
        quo_q[j] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[QW-1];
endmodule
`default_nettype wire

// ===== rtl/vec4_arith_normalize_unit.sv =====
// Throughput: one item per cycle while no finished result waits at the output;
// the stages are the lane multipliers, a 32-stage square-root pipeline and a
// FRAC_BITS+1 stage divider in each lane (data are Q16.16 at the default).
// The whole pipeline holds while a finished result waits at the output.
// Reset clears all stage valid bits and sets min_length to 7.
`default_nettype none
module vec4_arith_normalize_unit #(
  parameter int FRAC_BITS = v4n_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [v4n_pkg::MIN_LEN_W-1:0] cfg_wdata_i,
  v4n_in_if.sink                             in_i,
  v4n_out_if.source                          out_o
);
  import v4n_pkg::*;

  localparam int NW = FRAC_BITS + 34;
  localparam int QW = FRAC_BITS + 1;
  localparam int PL = QW + 1;

  typedef struct packed {
    logic [2:0]       action;
    logic [3:0][31:0] r;
    logic             sat;
    logic [3:0]       neg;
    logic [3:0][31:0] abs;
    logic             carry;
  } line_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [3:0][31:0] r;
    logic             sat;
    logic [3:0]       neg;
    logic             shrt;
    logic [MAG_W-1:0] mag;
    logic             sat_len;
  } post_t;

  logic                 en;
  logic [MIN_LEN_W-1:0] min_len_q;
  logic signed [31:0]   a_in [4];
  logic signed [31:0]   b_in [4];
  lane_out_t            lane_res [4];
  logic [2:0]           act_lane_q;
  logic                 v_lane_q;
  logic [64:0]          sum_q;
  line_t                line0_d;
  line_t                line1_d;
  line_t                line_q [SQ_STAGES+1];
  logic [SQ_STAGES:0]   vline_q;
  logic [31:0]          root;
  logic [LEN_W-1:0]     len;
  post_t                post_d;
  post_t                post_q [PL];
  logic [PL-1:0]        vpost_q;
  logic [NW-1:0]        num_q [4];
  logic [LEN_W-1:0]     den_q;
  logic [QW-1:0]        quo [4];
  logic [3:0][31:0]     r_fin;
  logic                 out_valid_q;
  logic [3:0][31:0]     out_r_q;
  logic [MAG_W-1:0]     out_mag_q;
  logic                 out_short_q;
  logic                 out_sat_q;

  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  assign a_in[0] = in_i.a_x;
  assign a_in[1] = in_i.a_y;
  assign a_in[2] = in_i.a_z;
  assign a_in[3] = in_i.a_w;
  assign b_in[0] = in_i.b_x;
  assign b_in[1] = in_i.b_y;
  assign b_in[2] = in_i.b_z;
  assign b_in[3] = in_i.b_w;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    v4n_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .action_i(in_i.action),
      .a_i     (a_in[i]),
      .b_i     (b_in[i]),
      .res_o   (lane_res[i])
    );
    v4n_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i(clk_i),
      .en_i (en),
      .num_i(num_q[i]),
      .den_i(den_q),
      .quo_o(quo[i])
    );
  end

  v4n_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .v_i   (sum_q[63:0]),
    .root_o(root)
  );

  always_comb begin
    line0_d.action = act_lane_q;
    line0_d.carry  = 1'b0;
    line0_d.sat    = lane_res[0].sat | lane_res[1].sat
                   | lane_res[2].sat | lane_res[3].sat;
    for (int i = 0; i < 4; i++) begin
      line0_d.r[i]   = lane_res[i].r;
      line0_d.neg[i] = lane_res[i].neg;
      line0_d.abs[i] = lane_res[i].abs;
    end
    line1_d       = line_q[0];
    line1_d.carry = sum_q[64];
  end

  always_comb begin
    len = line_q[SQ_STAGES].carry ? (LEN_W'(1) << 32) : LEN_W'(root);
    post_d.action  = line_q[SQ_STAGES].action;
    post_d.r       = line_q[SQ_STAGES].r;
    post_d.sat     = line_q[SQ_STAGES].sat;
    post_d.neg     = line_q[SQ_STAGES].neg;
    post_d.shrt    = (len == '0) || (len < LEN_W'(min_len_q));
    post_d.sat_len = len[LEN_W-1] || len[LEN_W-2];
    post_d.mag     = post_d.sat_len ? MAG_MAX : len[MAG_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      r_fin[i] = post_q[PL-1].neg[i] ? -(32'(quo[i])) : 32'(quo[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q   <= MIN_LEN_RST;
      v_lane_q    <= 1'b0;
      vline_q     <= '0;
      vpost_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_len_q <= cfg_wdata_i;
      end
      if (en) begin
        v_lane_q    <= in_i.valid;
        vline_q     <= {vline_q[SQ_STAGES-1:0], v_lane_q};
        vpost_q     <= {vpost_q[PL-2:0], vline_q[SQ_STAGES]};
        out_valid_q <= vpost_q[PL-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act_lane_q <= in_i.action;
      sum_q      <= 65'(lane_res[0].sq) + 65'(lane_res[1].sq)
                  + 65'(lane_res[2].sq) + 65'(lane_res[3].sq);
      line_q[0] <= line0_d;
      line_q[1] <= line1_d;
      for (int i = 2; i <= SQ_STAGES; i++) begin
        line_q[i] <= line_q[i-1];
      end
      post_q[0] <= post_d;
      for (int i = 1; i < PL; i++) begin
        post_q[i] <= post_q[i-1];
      end
      den_q <= len;
      for (int i = 0; i < 4; i++) begin
        num_q[i] <= (NW'(line_q[SQ_STAGES].abs[i]) << FRAC_BITS) + NW'(len >> 1);
      end
      case (post_q[PL-1].action)
        ACT_NORM: begin
          out_r_q     <= post_q[PL-1].shrt ? '0 : r_fin;
          out_mag_q   <= post_q[PL-1].mag;
          out_short_q <= post_q[PL-1].shrt;
          out_sat_q   <= post_q[PL-1].sat_len;
        end
        ACT_LEN: begin
          out_r_q     <= '0;
          out_mag_q   <= post_q[PL-1].mag;
          out_short_q <= 1'b0;
          out_sat_q   <= post_q[PL-1].sat_len;
        end
        default: begin
          out_r_q     <= post_q[PL-1].r;
          out_mag_q   <= '0;
          out_short_q <= 1'b0;
          out_sat_q   <= post_q[PL-1].sat;
        end
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.r_x       = out_r_q[0];
  assign out_o.r_y       = out_r_q[1];
  assign out_o.r_z       = out_r_q[2];
  assign out_o.r_w       = out_r_q[3];
  assign out_o.magnitude = out_mag_q;
  assign out_o.too_short = out_short_q;
  assign out_o.saturated = out_sat_q;

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.too_short |->
      out_o.r_x == 0 && out_o.r_y == 0 && out_o.r_z == 0 && out_o.r_w == 0)
    else $error("too_short result carries a nonzero vector");

  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.too_short |->
      out_o.magnitude == 0 || MIN_LEN_W'(out_o.magnitude) < min_len_q)
    else $error("too_short set with length at or above threshold");

  a_sat_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated && out_o.magnitude != 0 |->
      out_o.magnitude == MAG_MAX)
    else $error("saturated length not clipped to maximum");

endmodule
`default_nettype wire
